>>> rtl/huf_pkg.sv
`default_nettype none

package huf_pkg;

  localparam int NUM_SYMBOLS_DEF = 32;

  localparam int FREQ_W   = 32;
  localparam int WSUM_W   = 37;
  localparam int ID_W     = 6;
  localparam int MAXV_W   = 5;
  localparam int TDATA_W  = 56;
  localparam int TUSER_W  = 2;

  localparam logic [MAXV_W-1:0] MAXV_RESET = 5'd31;

  localparam logic KIND_MERGE = 1'b0;
  localparam logic KIND_ROOT  = 1'b1;

  typedef enum logic [0:0] {
    S_LOAD  = 1'b0,
    S_BUILD = 1'b1
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic            insert_leaf;
    logic            merge;
    logic            root;
    logic            empty;
    logic [ID_W-1:0] new_id;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> rtl/huf_ctrl.sv
`default_nettype none

module huf_ctrl #(
  parameter int NUM_SYMBOLS = huf_pkg::NUM_SYMBOLS_DEF,
  parameter int SYM_W       = $clog2(NUM_SYMBOLS),
  parameter int CNT_W       = $clog2(NUM_SYMBOLS + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [huf_pkg::MAXV_W-1:0] cfg_wdata,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [huf_pkg::FREQ_W-1:0] freq,
  input  wire huf_pkg::sts_t             sts,
  output huf_pkg::cmd_t                  cmd,
  output logic [CNT_W-1:0]               len
);

  localparam int CW = (SYM_W > huf_pkg::MAXV_W) ? SYM_W : huf_pkg::MAXV_W;

  huf_pkg::state_t state, state_next;
  logic [huf_pkg::MAXV_W-1:0] sym_limit;
  logic [SYM_W-1:0] sym_cnt, sym_cnt_next;
  logic [SYM_W-1:0] internal_cnt, internal_cnt_next;
  logic [CNT_W-1:0] len_next;
  logic [CW-1:0] last_sym;
  logic          run_done;
  logic [huf_pkg::ID_W:0] parent_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= huf_pkg::S_LOAD;
      sym_limit    <= huf_pkg::MAXV_RESET;
      sym_cnt      <= '0;
      internal_cnt <= '0;
      len          <= '0;
    end else begin
      state        <= state_next;
      sym_cnt      <= sym_cnt_next;
      internal_cnt <= internal_cnt_next;
      len          <= len_next;
      if (cfg_we) begin
        sym_limit <= cfg_wdata;
      end
    end
  end

  assign last_sym = (CW'(sym_limit) > CW'(NUM_SYMBOLS - 1)) ? CW'(NUM_SYMBOLS - 1)
                                                            : CW'(sym_limit);
  assign run_done = CW'(sym_cnt) >= last_sym;
  assign parent_sum = (huf_pkg::ID_W + 1)'(NUM_SYMBOLS)
                    + (huf_pkg::ID_W + 1)'(internal_cnt);

  always_comb begin
    state_next        = state;
    sym_cnt_next      = sym_cnt;
    internal_cnt_next = internal_cnt;
    len_next          = len;
    in_ready          = 1'b0;
    cmd               = '0;
    unique case (state)
      huf_pkg::S_LOAD: begin
        in_ready   = 1'b1;
        cmd.new_id = huf_pkg::ID_W'(sym_cnt);
        if (in_valid) begin
          if (freq != '0 && len < CNT_W'(NUM_SYMBOLS)) begin
            cmd.insert_leaf = 1'b1;
            len_next        = len + CNT_W'(1);
          end
          if (run_done) begin
            sym_cnt_next = '0;
            state_next   = huf_pkg::S_BUILD;
          end else begin
            sym_cnt_next = sym_cnt + SYM_W'(1);
          end
        end
      end
      huf_pkg::S_BUILD: begin
        cmd.new_id = parent_sum[huf_pkg::ID_W-1:0];
        if (sts.out_free) begin
          if (len < CNT_W'(2)) begin
            // one node left, or none at all
            cmd.root          = 1'b1;
            cmd.empty         = (len == '0);
            len_next          = '0;
            internal_cnt_next = '0;
            state_next        = huf_pkg::S_LOAD;
          end else begin
            cmd.merge         = 1'b1;
            len_next          = len - CNT_W'(1);
            internal_cnt_next = internal_cnt + SYM_W'(1);
          end
        end
      end
      default: begin
        state_next = huf_pkg::S_LOAD;
      end
    endcase
  end

  a_merge_needs_two: assert property (@(posedge clk) disable iff (rst)
    cmd.merge |-> len >= CNT_W'(2))
    else $error("merge issued with fewer than two nodes");

  a_root_ends_run: assert property (@(posedge clk) disable iff (rst)
    cmd.root |=> (state == huf_pkg::S_LOAD) && (len == '0) && (internal_cnt == '0))
    else $error("run state not cleared after root record");

  a_out_space: assert property (@(posedge clk) disable iff (rst)
    (cmd.merge || cmd.root) |-> sts.out_free)
    else $error("record issued while output register is held");

  a_node_budget: assert property (@(posedge clk) disable iff (rst)
    (state == huf_pkg::S_BUILD) |-> (int'(internal_cnt) + int'(len)) <= NUM_SYMBOLS)
    else $error("node count exceeds symbol count");

endmodule

`default_nettype wire

>>> rtl/huf_dpath.sv
`default_nettype none

module huf_dpath #(
  parameter int NUM_SYMBOLS = huf_pkg::NUM_SYMBOLS_DEF,
  parameter int CNT_W       = $clog2(NUM_SYMBOLS + 1)
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire huf_pkg::cmd_t               cmd,
  input  wire logic [CNT_W-1:0]            len,
  input  wire logic [huf_pkg::FREQ_W-1:0]  freq,
  output huf_pkg::sts_t                    sts,
  input  wire logic                        out_ready,
  output logic                             out_valid,
  output logic [huf_pkg::TDATA_W-1:0]      out_data,
  output logic [huf_pkg::TUSER_W-1:0]      out_user,
  output logic                             out_last
);

  // List kept in reverse order: cell 0 holds the lightest, most recent entry.
  logic [huf_pkg::WSUM_W-1:0] cell_w  [NUM_SYMBOLS];
  logic [huf_pkg::ID_W-1:0]   cell_id [NUM_SYMBOLS];
  logic [huf_pkg::WSUM_W-1:0] rem_w   [NUM_SYMBOLS];
  logic [huf_pkg::ID_W-1:0]   rem_id  [NUM_SYMBOLS];
  logic [huf_pkg::WSUM_W-1:0] nxt_w   [NUM_SYMBOLS];
  logic [huf_pkg::ID_W-1:0]   nxt_id  [NUM_SYMBOLS];
  logic [NUM_SYMBOLS-1:0]     lt;

  logic [huf_pkg::WSUM_W-1:0] pair_sum;
  logic [huf_pkg::WSUM_W-1:0] new_w;
  logic [CNT_W-1:0]           rem_len;

  logic                       out_kind, out_empty;
  logic [huf_pkg::ID_W-1:0]   out_parent, out_left, out_right;
  logic [huf_pkg::WSUM_W-1:0] out_wsum;

  assign pair_sum = cell_w[0] + cell_w[1];
  assign new_w    = cmd.merge ? pair_sum : huf_pkg::WSUM_W'(freq);
  assign rem_len  = cmd.merge ? (len - CNT_W'(2)) : len;

  for (genvar i = 0; i < NUM_SYMBOLS; i++) begin : g_cell
    // remaining list after dropping the merged pair
    if (i + 2 < NUM_SYMBOLS) begin : g_rem
      assign rem_w[i]  = cmd.merge ? cell_w[i+2]  : cell_w[i];
      assign rem_id[i] = cmd.merge ? cell_id[i+2] : cell_id[i];
    end else begin : g_rem_end
      assign rem_w[i]  = cell_w[i];
      assign rem_id[i] = cell_id[i];
    end

    assign lt[i] = (CNT_W'(i) < rem_len) && (rem_w[i] < new_w);

    if (i == 0) begin : g_head
      assign nxt_w[i]  = lt[i] ? rem_w[i]  : new_w;
      assign nxt_id[i] = lt[i] ? rem_id[i] : cmd.new_id;
    end else begin : g_body
      assign nxt_w[i]  = lt[i] ? rem_w[i]  : (lt[i-1] ? new_w      : rem_w[i-1]);
      assign nxt_id[i] = lt[i] ? rem_id[i] : (lt[i-1] ? cmd.new_id : rem_id[i-1]);
    end

    always_ff @(posedge clk) begin
      if (cmd.insert_leaf || cmd.merge) begin
        cell_w[i]  <= nxt_w[i];
        cell_id[i] <= nxt_id[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.merge || cmd.root) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.merge) begin
      out_kind   <= huf_pkg::KIND_MERGE;
      out_parent <= cmd.new_id;
      out_left   <= cell_id[1];
      out_right  <= cell_id[0];
      out_wsum   <= pair_sum;
      out_empty  <= 1'b0;
      out_last   <= 1'b0;
    end else if (cmd.root) begin
      out_kind   <= huf_pkg::KIND_ROOT;
      out_parent <= cmd.empty ? '0 : cell_id[0];
      out_left   <= '0;
      out_right  <= '0;
      out_wsum   <= cmd.empty ? '0 : cell_w[0];
      out_empty  <= cmd.empty;
      out_last   <= 1'b1;
    end
  end

  assign out_data = {1'b0, out_wsum, out_right, out_left, out_parent};
  assign out_user = {out_empty, out_kind};
  assign sts.out_free = !out_valid || out_ready;

endmodule

`default_nettype wire

>>> rtl/huffman_tree_builder_core.sv
// Loading: one frequency item per cycle; items before the last symbol give no result.
// Build: the final item starts the build state, which issues one merge record per cycle
// (list length minus one records) and then the root record into the output register;
// each record waits while that register is held. s_axis_tready stays low until the root
// issues. Every merge reinserts the new node into the sorted cell row.
// Reset (rst, synchronous): counters cleared, symbol limit back to 31, output empty.
`default_nettype none

module huffman_tree_builder_core #(
  parameter int NUM_SYMBOLS = huf_pkg::NUM_SYMBOLS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [huf_pkg::MAXV_W-1:0]   cfg_wdata,      // last symbol limit
  input  wire logic                         s_axis_tvalid,
  output logic                              s_axis_tready,
  input  wire logic [huf_pkg::FREQ_W-1:0]   s_axis_tdata,   // [31:0] freq
  output logic                              m_axis_tvalid,
  input  wire logic                         m_axis_tready,
  // [5:0] parent_id, [11:6] left_id, [17:12] right_id, [54:18] weight_sum, [55] zero
  output logic [huf_pkg::TDATA_W-1:0]       m_axis_tdata,
  output logic [huf_pkg::TUSER_W-1:0]       m_axis_tuser,   // [0] record_kind, [1] tree_empty
  output logic                              m_axis_tlast
);

  localparam int SYM_W = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
  localparam int CNT_W = $clog2(NUM_SYMBOLS + 1);

  huf_pkg::cmd_t    cmd;
  huf_pkg::sts_t    sts;
  logic [CNT_W-1:0] len;

  huf_ctrl #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .SYM_W       (SYM_W),
    .CNT_W       (CNT_W)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .freq      (s_axis_tdata),
    .sts       (sts),
    .cmd       (cmd),
    .len       (len)
  );

  huf_dpath #(
    .NUM_SYMBOLS (NUM_SYMBOLS),
    .CNT_W       (CNT_W)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .len       (len),
    .freq      (s_axis_tdata),
    .sts       (sts),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

endmodule

`default_nettype wire
